@@ hw/rtl/whdt_pkg.sv @@
// Shared constants, types and the arctangent table for the waypoint heading unit.
package whdt_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;

    // guard bits and vectoring register width (offset, guard, gain growth, sign)
    localparam int GUARD     = 36 - COORD_WIDTH;
    localparam int XW        = COORD_WIDTH + GUARD + 4;
    localparam int CNT_W     = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ATAN_IW   = 5;
    localparam int ZW        = 32;

    // gain multiply, done as two partial products
    localparam int GAIN_W    = 24;
    localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10187995;
    localparam int MUL_SPLIT = XW / 2;
    localparam int HI_W      = XW - 1 - MUL_SPLIT;
    localparam int PLO_W     = MUL_SPLIT + GAIN_W;
    localparam int PHI_W     = HI_W + GAIN_W;
    localparam int SUM_W     = XW - 1 + GAIN_W;
    localparam int DSUM_W    = SUM_W - GAIN_W;
    localparam int DRND_W    = XW - GUARD;

    localparam int DIST_W    = 17;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic [ANGLE_WIDTH-1:0] HALF    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_CCW  = 2'd1,
        TURN_CW   = 2'd2
    } turn_dir_t;

    typedef struct packed {
        logic                          mode;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } whdt_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]      distance;
        logic [ANGLE_WIDTH-1:0] heading;
        turn_dir_t              turn_dir;
        logic [ANGLE_WIDTH-1:0] turn_amount;
    } whdt_out_t;

    typedef struct packed {
        logic             load_in;
        logic             setup;
        logic             iter;
        logic [CNT_W-1:0] iter_idx;
        logic             mul_lo;
        logic             mul_hi;
        logic             sum;
        logic             rnd;
        logic             fin;
    } whdt_cmd_t;

    typedef struct packed {
        logic need_cordic;
    } whdt_status_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [ZW-1:0] atan_turn(input logic [ATAN_IW-1:0] idx);
        logic [ZW-1:0] a;
        case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/waypoint_heading_distance_turn_top.sv @@
// Top level of the waypoint heading, distance and turn unit.
//
// Input channel s_valid / s_ready / s_data carries one waypoint word: mode,
// absolute point_x and point_y in signed Q8.8. Result channel m_valid /
// m_ready / m_data carries distance (unsigned Q9.8), the new heading as a
// binary angle, and the shortest turn (direction and amount).
// One word is in work at a time; s_ready is high only while the sequencer
// idles. A general offset goes through a setup step, CORDIC_STEPS iterations
// of the single shared shift-add vectoring unit, the gain multiply split into
// two partial products, summing, rounding, and a final step that loads the
// result register. Axis-aligned or zero offsets and return-to-zero words
// skip the vectoring and go from setup straight to the final step. A
// finished result sits in the output register, so the next word is
// accepted while it waits; if m_ready stays low the following result holds
// in the final step until the register frees up.
// Reset (aresetn low, synchronous) clears the previous waypoint and heading
// to zero and drops any word in flight.
module waypoint_heading_distance_turn_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  whdt_pkg::whdt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output whdt_pkg::whdt_out_t m_data
);
    import whdt_pkg::*;

    whdt_cmd_t    cmd;
    whdt_status_t status;

    whdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    whdt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

@@ hw/rtl/whdt_ctrl.sv @@
// Sequencer: steps one word through setup, vectoring and gain multiply when needed, and the result register.
module whdt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  whdt_pkg::whdt_status_t status,
    output whdt_pkg::whdt_cmd_t    cmd
);
    import whdt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ITER,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_RND,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             fin_go;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign fin_go  = (state_reg == ST_FIN) && (!out_valid_reg || m_ready);

    always_comb begin
        cmd          = '0;
        cmd.load_in  = s_valid && (state_reg == ST_IDLE);
        cmd.setup    = (state_reg == ST_SETUP);
        cmd.iter     = (state_reg == ST_ITER);
        cmd.iter_idx = cnt_reg;
        cmd.mul_lo   = (state_reg == ST_MUL_LO);
        cmd.mul_hi   = (state_reg == ST_MUL_HI);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.rnd      = (state_reg == ST_RND);
        cmd.fin      = fin_go;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cnt_next   = '0;
                state_next = status.need_cordic ? ST_ITER : ST_FIN;
            end
            ST_ITER: begin
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    state_next = ST_MUL_LO;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_RND;
            ST_RND:    state_next = ST_FIN;
            ST_FIN: begin
                if (fin_go) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/whdt_dp.sv @@
// Datapath: offsets, shared CORDIC shift-add unit, split gain multiply, turn logic, result register.
module whdt_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  whdt_pkg::whdt_in_t     s_data,
    output whdt_pkg::whdt_out_t    m_data,
    input  whdt_pkg::whdt_cmd_t    cmd,
    output whdt_pkg::whdt_status_t status
);
    import whdt_pkg::*;

    // input word and kept state
    logic                          mode_reg;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] last_x_reg, last_x_next;
    logic signed [COORD_WIDTH-1:0] last_y_reg, last_y_next;
    logic [ANGLE_WIDTH-1:0]        heading_reg, heading_next;

    // vectoring unit
    logic signed [XW-1:0] x_reg, y_reg;
    logic [ZW-1:0]        z_reg;
    logic signed [XW-1:0] xs, ys;
    logic [ZW-1:0]        atan_val;

    // gain multiply and rounding
    logic [XW-2:0]        xpos;
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;
    logic [SUM_W-1:0]     sum_full;
    logic [DSUM_W-1:0]    dsum_reg;
    logic [XW-1:0]        drnd;
    logic [DRND_W-1:0]    dshift;
    logic [ZW-1:0]        zr;

    // per-word result before the output register
    logic [DIST_W-1:0]      dist_reg;
    logic [ANGLE_WIDTH-1:0] head_reg;
    whdt_out_t              out_reg;

    // setup arithmetic
    logic signed [COORD_WIDTH:0] dx, dy;
    logic signed [XW-1:0]        x0, y0;

    // turn logic
    logic [ANGLE_WIDTH:0]   end_ext;
    logic [ANGLE_WIDTH-1:0] diff;
    turn_dir_t              tdir;
    logic [ANGLE_WIDTH-1:0] tamt;

    assign dx = (COORD_WIDTH + 1)'(px_reg) - (COORD_WIDTH + 1)'(last_x_reg);
    assign dy = (COORD_WIDTH + 1)'(py_reg) - (COORD_WIDTH + 1)'(last_y_reg);
    assign x0 = XW'(dx) <<< GUARD;
    assign y0 = XW'(dy) <<< GUARD;

    assign status.need_cordic = !mode_reg && (dx != '0) && (dy != '0);

    assign xs       = y_reg >>> cmd.iter_idx;
    assign ys       = x_reg >>> cmd.iter_idx;
    assign atan_val = atan_turn(ATAN_IW'(cmd.iter_idx));

    // final x should never be negative; clamp anyway
    assign xpos     = x_reg[XW-1] ? '0 : x_reg[XW-2:0];
    assign sum_full = (SUM_W'(phi_reg) << MUL_SPLIT) + SUM_W'(plo_reg)
                    + (SUM_W'(1) << (GAIN_W - 1));
    assign drnd     = XW'(dsum_reg) + (XW'(1) << (GUARD - 1));
    assign dshift   = drnd[XW-1:GUARD];
    assign zr       = z_reg + (ZW'(1) << (ZW - ANGLE_WIDTH - 1));

    // return-to-zero treats the end heading as a full turn
    assign end_ext = {mode_reg, head_reg};
    assign diff    = head_reg - heading_reg;

    always_comb begin
        if (diff == '0) begin
            tdir = TURN_NONE;
            tamt = '0;
        end else if (diff == HALF) begin
            tdir = ({1'b0, heading_reg} > end_ext) ? TURN_CCW : TURN_CW;
            tamt = HALF;
        end else if (diff < HALF) begin
            tdir = TURN_CCW;
            tamt = diff;
        end else begin
            tdir = TURN_CW;
            tamt = -diff;
        end
    end

    always_comb begin
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        heading_next = heading_reg;
        if (cmd.fin) begin
            heading_next = head_reg;
            if (!mode_reg) begin
                last_x_next = px_reg;
                last_y_next = py_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            heading_reg <= '0;
        end else begin
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            heading_reg <= heading_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_data.mode;
            px_reg   <= s_data.point_x;
            py_reg   <= s_data.point_y;
        end

        if (cmd.setup) begin
            if (mode_reg) begin
                dist_reg <= '0;
                head_reg <= '0;
            end else if (dx == '0 && dy == '0) begin
                dist_reg <= '0;
                head_reg <= heading_reg;
            end else if (dx == '0) begin
                dist_reg <= dy[COORD_WIDTH] ? DIST_W'(-dy) : DIST_W'(dy);
                head_reg <= dy[COORD_WIDTH] ? ANGLE_WIDTH'(3 * QUARTER) : QUARTER;
            end else if (dy == '0) begin
                dist_reg <= dx[COORD_WIDTH] ? DIST_W'(-dx) : DIST_W'(dx);
                head_reg <= dx[COORD_WIDTH] ? HALF : '0;
            end
            // mirror into the right half plane, adding a half turn
            if (dx[COORD_WIDTH]) begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= ZW'(1) << (ZW - 1);
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end

        if (cmd.iter) begin
            if (!y_reg[XW-1]) begin
                x_reg <= x_reg + xs;
                y_reg <= y_reg - ys;
                z_reg <= z_reg + atan_val;
            end else begin
                x_reg <= x_reg - xs;
                y_reg <= y_reg + ys;
                z_reg <= z_reg - atan_val;
            end
        end

        if (cmd.mul_lo) begin
            plo_reg <= PLO_W'(xpos[MUL_SPLIT-1:0]) * PLO_W'(GAIN_Q24);
        end
        if (cmd.mul_hi) begin
            phi_reg <= PHI_W'(xpos[XW-2:MUL_SPLIT]) * PHI_W'(GAIN_Q24);
        end
        if (cmd.sum) begin
            dsum_reg <= sum_full[SUM_W-1:GAIN_W];
        end
        if (cmd.rnd) begin
            dist_reg <= (dshift > DRND_W'(DIST_MAX)) ? DIST_MAX : dshift[DIST_W-1:0];
            head_reg <= zr[ZW-1:ZW-ANGLE_WIDTH];
        end

        if (cmd.fin) begin
            out_reg.distance    <= dist_reg;
            out_reg.heading     <= head_reg;
            out_reg.turn_dir    <= tdir;
            out_reg.turn_amount <= tamt;
        end
    end

    assign m_data = out_reg;

endmodule

@@ tb/waypoint_heading_distance_turn_top_test.sv @@
// Self-checking testbench for the waypoint heading, distance and turn unit.
`timescale 1ns / 100ps

module waypoint_heading_distance_turn_top_test;
    import whdt_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1700;
    localparam int CALM_TAIL = 120;

    // arctangent of 2^-i, 32-bit binary angle
    localparam bit [31:0] ATAN_Z [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    whdt_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    whdt_out_t m_data;

    waypoint_heading_distance_turn_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    whdt_in_t  waypoint_q[$];
    whdt_out_t predicted_legs[$];

    // predictor state
    logic signed [COORD_WIDTH-1:0] prev_x = '0;
    logic signed [COORD_WIDTH-1:0] prev_y = '0;
    logic [ANGLE_WIDTH-1:0]        cur_heading = '0;

    // generator's view of the last waypoint
    logic [COORD_WIDTH-1:0] gen_x = '0;
    logic [COORD_WIDTH-1:0] gen_y = '0;

    int words_sent = 0;
    int words_taken = 0;
    int legs_checked = 0;
    int n_returns = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int feed_gap = 0;
    int sink_stall = 0;
    logic calm;

    assign calm = (waypoint_q.size() < CALM_TAIL);

    function automatic void cordic_polar(input longint dx, input longint dy,
                                         output longint unsigned mag,
                                         output logic [ANGLE_WIDTH-1:0] ang);
        longint x, y, xs, ys;
        logic [31:0] z;
        longint unsigned d;
        logic [63:0] r;
        x = dx * (longint'(1) << GUARD);
        y = dy * (longint'(1) << GUARD);
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (y >= 0) begin
                x = x + xs;
                y = y - ys;
                z = z + ATAN_Z[i];
            end else begin
                x = x - xs;
                y = y + ys;
                z = z - ATAN_Z[i];
            end
        end
        if (x < 0)
            x = 0;
        d = (longint'(unsigned'(x)) * 64'd10187995 + (64'd1 << 23)) >> 24;
        d = (d + (64'd1 << (GUARD - 1))) >> GUARD;
        mag = d;
        r = ({32'd0, z} + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH);
        ang = r[ANGLE_WIDTH-1:0];
    endfunction

    function automatic void shortest_turn(input logic [ANGLE_WIDTH:0] s,
                                          input logic [ANGLE_WIDTH:0] e,
                                          output turn_dir_t dir,
                                          output logic [ANGLE_WIDTH-1:0] amt);
        logic [ANGLE_WIDTH-1:0] diff;
        diff = ANGLE_WIDTH'(e - s);
        if (diff == '0) begin
            dir = TURN_NONE;
            amt = '0;
        end else if (diff == HALF) begin
            dir = (s > e) ? TURN_CCW : TURN_CW;
            amt = HALF;
        end else if (diff < HALF) begin
            dir = TURN_CCW;
            amt = diff;
        end else begin
            dir = TURN_CW;
            amt = -diff;
        end
    endfunction

    // next leg from the current waypoint and heading; updates predictor state
    function automatic whdt_out_t plan_leg(input whdt_in_t w);
        whdt_out_t leg;
        longint dx, dy;
        longint unsigned leg_len;
        logic [ANGLE_WIDTH-1:0] head, start, amt;
        turn_dir_t dir;
        start = cur_heading;
        leg_len = 0;
        if (w.mode) begin
            // end heading counts as one full turn
            shortest_turn({1'b0, start}, {1'b1, {ANGLE_WIDTH{1'b0}}}, dir, amt);
            head = '0;
            n_returns++;
        end else begin
            dx = longint'(w.point_x) - longint'(prev_x);
            dy = longint'(w.point_y) - longint'(prev_y);
            if (dx == 0 && dy == 0) begin
                head = start;
            end else if (dx == 0) begin
                leg_len = (dy < 0) ? -dy : dy;
                head = (dy > 0) ? QUARTER : HALF + QUARTER;
            end else if (dy == 0) begin
                leg_len = (dx < 0) ? -dx : dx;
                head = (dx > 0) ? '0 : HALF;
            end else begin
                cordic_polar(dx, dy, leg_len, head);
            end
            shortest_turn({1'b0, start}, {1'b0, head}, dir, amt);
            prev_x = w.point_x;
            prev_y = w.point_y;
        end
        cur_heading = head;
        leg.distance = (leg_len > DIST_MAX) ? DIST_MAX : DIST_W'(leg_len);
        leg.heading = head;
        leg.turn_dir = dir;
        leg.turn_amount = amt;
        return leg;
    endfunction

    task automatic add_waypoint(input logic m, input logic [COORD_WIDTH-1:0] x,
                                input logic [COORD_WIDTH-1:0] y);
        whdt_in_t w;
        w.mode = m;
        w.point_x = x;
        w.point_y = y;
        waypoint_q.push_back(w);
        if (!m) begin
            gen_x = x;
            gen_y = y;
        end
    endtask

    // acceptance on both channels, checking and watchdog
    always @(posedge aclk) begin
        whdt_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_legs.push_back(plan_leg(s_data));
                words_taken++;
            end
            if (m_valid && m_ready) begin
                if (predicted_legs.size() == 0) begin
                    $display("%0t: result word with nothing pending: %p", $time, m_data);
                    errors++;
                end else begin
                    want = predicted_legs.pop_front();
                    if (m_data.distance !== want.distance) begin
                        $display("%0t: distance expected %0d got %0d",
                                 $time, want.distance, m_data.distance);
                        errors++;
                    end
                    if (m_data.heading !== want.heading) begin
                        $display("%0t: heading expected %0d got %0d",
                                 $time, want.heading, m_data.heading);
                        errors++;
                    end
                    if (m_data.turn_dir !== want.turn_dir) begin
                        $display("%0t: turn_dir expected %0d got %0d",
                                 $time, want.turn_dir, m_data.turn_dir);
                        errors++;
                    end
                    if (m_data.turn_amount !== want.turn_amount) begin
                        $display("%0t: turn_amount expected %0d got %0d",
                                 $time, want.turn_amount, m_data.turn_amount);
                        errors++;
                    end
                    legs_checked++;
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else if (waypoint_q.size() > 0 || words_sent != words_taken
                         || predicted_legs.size() > 0) begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: no progress for %0d cycles, %0d results pending",
                             $time, quiet_cycles, predicted_legs.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // waypoint driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (words_sent != words_taken) begin
            // word still waiting for s_ready
        end else if (feed_gap > 0) begin
            feed_gap--;
            s_valid <= 1'b0;
        end else if (waypoint_q.size() > 0 && !calm && $urandom_range(0, 7) == 0) begin
            feed_gap = $urandom_range(1, 17) - 1;
            s_valid <= 1'b0;
        end else if (waypoint_q.size() > 0) begin
            s_data <= waypoint_q.pop_front();
            s_valid <= 1'b1;
            words_sent++;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result sink with random back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int kind;
        logic [COORD_WIDTH-1:0] rx, ry;

        // directed: zero offset from reset, axis moves, both half-turn rules
        add_waypoint(1'b0, 16'sd0, 16'sd0);
        add_waypoint(1'b0, 16'sd256, 16'sd0);
        add_waypoint(1'b0, 16'sd256, 16'sd512);
        add_waypoint(1'b0, 16'sd256, -16'sd512);
        add_waypoint(1'b0, 16'sd256, 16'sd256);
        add_waypoint(1'b0, -16'sd32768, 16'sd256);
        add_waypoint(1'b0, 16'sd32767, 16'sd256);
        // field extremes, longest offsets
        add_waypoint(1'b0, -16'sd32768, -16'sd32768);
        add_waypoint(1'b0, 16'sd32767, 16'sd32767);
        add_waypoint(1'b0, -16'sd32768, 16'sd32767);
        add_waypoint(1'b0, 16'sd32767, -16'sd32768);
        add_waypoint(1'b0, 16'sd32767, -16'sd32768);
        // return to zero: nonzero heading, zero heading, exact half turn
        add_waypoint(1'b1, 16'h1234, 16'hFFFF);
        add_waypoint(1'b1, 16'h0000, 16'h0000);
        add_waypoint(1'b0, 16'sd0, -16'sd32768);
        add_waypoint(1'b1, 16'hFFFF, 16'h8000);
        // unit diagonals in each quadrant
        add_waypoint(1'b0, 16'sd1, -16'sd32767);
        add_waypoint(1'b0, 16'sd0, -16'sd32766);
        add_waypoint(1'b0, -16'sd1, -16'sd32767);
        add_waypoint(1'b0, 16'sd0, -16'sd32768);
        add_waypoint(1'b0, -16'sd5, -16'sd32760);
        add_waypoint(1'b1, 16'h5555, 16'hAAAA);
        add_waypoint(1'b0, 16'sd3000, 16'sd2000);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 99);
            rx = $urandom();
            ry = $urandom();
            if (kind < 10) begin
                add_waypoint(1'b1, rx, ry);
            end else if (kind < 18) begin
                add_waypoint(1'b0, gen_x, ry);
            end else if (kind < 26) begin
                add_waypoint(1'b0, rx, gen_y);
            end else if (kind < 31) begin
                add_waypoint(1'b0, gen_x, gen_y);
            end else if (kind < 55) begin
                add_waypoint(1'b0, gen_x + 16'($urandom_range(0, 16)) - 16'd8,
                             gen_y + 16'($urandom_range(0, 16)) - 16'd8);
            end else begin
                add_waypoint(1'b0, rx, ry);
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (waypoint_q.size() == 0 && words_sent == words_taken
              && predicted_legs.size() == 0);
        repeat (40) @(posedge aclk);

        $display("%0d waypoint words driven (%0d return-to-zero), %0d result words checked",
                 words_taken, n_returns, legs_checked);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
